// File: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the shunt current coulomb counter
// Holds field widths, calibration constants, direction and register codes,
// and the status record returned by the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package scc_pkg;

    // Datapath widths.
    localparam int NUM_W     = 40;   // calibration numerator, signed
    localparam int DVS_W     = 27;   // divisor width, holds 10^8
    localparam int MPLIER_W  = 15;   // serial multiplier operand, holds 26667
    localparam int ACC_W     = 32;   // charge accumulator
    localparam int CODE_W    = 14;   // current code
    localparam int STEP_W    = 8;    // percent step
    localparam int RAW_W     = 16;   // shunt register word
    localparam int GAIN_W    = 12;
    localparam int OFFS_W    = 22;
    localparam int CAP_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Calibration constants.
    localparam logic [MPLIER_W-1:0] COEF_UV     = 15'd26667;
    localparam logic [RAW_W-1:0]    SPLIT       = 16'd375;
    localparam logic [RAW_W-1:0]    WIN_MIN     = 16'd6;
    localparam logic [RAW_W-1:0]    WIN_MAX     = 16'd7500;
    localparam logic [GAIN_W-1:0]   K_MIN       = 12'd500;
    localparam logic [GAIN_W-1:0]   K_MAX       = 12'd2000;
    localparam logic [GAIN_W-1:0]   K_DEFAULT   = 12'd1000;
    localparam logic signed [OFFS_W-1:0] B_LIMIT     = 22'sd1000000;
    localparam logic signed [OFFS_W-1:0] B_LIMIT_NEG = -22'sd1000000;
    localparam logic [DVS_W-1:0]    DIV_CUR     = 27'd1000000;
    localparam logic [DVS_W-1:0]    DIV_CODE    = 27'd100000000;
    localparam logic [ACC_W-1:0]    SELF_USE    = 32'd20;
    localparam logic [CODE_W-1:0]   CODE_CENTER = 14'd5000;
    localparam logic [CODE_W-1:0]   CODE_MAX    = 14'd10000;

    // Result direction codes.
    typedef enum logic [1:0] {
        DIR_NONE      = 2'd0,
        DIR_DISCHARGE = 2'd1,
        DIR_CHARGE    = 2'd2
    } dir_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFS_DL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFS_DH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFS_CH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP     = 3'd6;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// File: rtl/scc_mul.sv
// ----------------------------------------------------------------------------
// scc_mul: bit-serial shift-and-add multiplier
// Consumes one multiplier bit per cycle, adding the shifted multiplicand to an
// accumulator that starts from a signed preset value.
// ----------------------------------------------------------------------------
module scc_mul #(
    parameter int A_W = 40,
    parameter int B_W = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [A_W-1:0]            mcand,
    input  logic [B_W-1:0]            mplier,
    input  logic signed [A_W-1:0]     init,
    output logic signed [A_W-1:0]     product,
    output scc_pkg::unit_status_t     status
);
    import scc_pkg::*;

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic signed [A_W-1:0] acc_reg;
    logic [A_W-1:0]        mcand_reg;
    logic [B_W-1:0]        mplier_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // One multiplier bit per cycle; the multiplicand shifts up alongside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            count_reg  <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg    <= init;
                mcand_reg  <= mcand;
                mplier_reg <= mplier;
                count_reg  <= '0;
                busy_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + $signed(mcand_reg);
                end
                mcand_reg  <= {mcand_reg[A_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[B_W-1:1]};
                if (count_reg == CNT_W'(B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/scc_div.sv
// ----------------------------------------------------------------------------
// scc_div: bit-serial restoring divider
// Produces one quotient bit per cycle for an unsigned dividend and divisor,
// leaving the quotient and the remainder in registers.
// ----------------------------------------------------------------------------
module scc_div #(
    parameter int N_W = 40,
    parameter int D_W = 27
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [N_W-1:0]        dividend,
    input  logic [D_W-1:0]        divisor,
    output logic [N_W-1:0]        quotient,
    output logic [D_W-1:0]        remainder,
    output scc_pkg::unit_status_t status
);
    import scc_pkg::*;

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[N_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    // Dividend bits leave at the top of quo_reg as quotient bits enter below.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg   <= dividend;
                rem_reg   <= '0;
                dvs_reg   <= divisor;
                count_reg <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], fits};
                if (count_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/shunt_current_coulomb_counter_top.sv
// ----------------------------------------------------------------------------
// shunt_current_coulomb_counter_top: shunt current calibration and coulomb count
// Calibrates raw shunt samples into a current code and a signed charge sum,
// and folds the sum into whole percent steps of capacity on request.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  --------------------------------------------
//  in       in_valid / in_stall  mode, shunt_raw
//  out      out_valid/out_stall  direction, current_code, percent_step,
//                                charge_sum
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
//  A sample inside the window runs two 15-step passes of the bit-serial
//  multiplier and a 40-step pass of the two restoring dividers. A fold
//  runs the divider pass only; a sample outside the window or a fold of a
//  zero sum uses neither unit. One item is processed at a time: in_stall is
//  high from transfer until the result is loaded, and the loaded result
//  waits on out_stall. Reset is asynchronous.
//
module shunt_current_coulomb_counter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [scc_pkg::RAW_W-1:0]       shunt_raw,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      direction,
    output logic [scc_pkg::CODE_W-1:0]      current_code,
    output logic [scc_pkg::STEP_W-1:0]      percent_step,
    output logic signed [scc_pkg::ACC_W-1:0] charge_sum,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scc_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import scc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_FINISH
    } state_t;

    // Configuration registers.
    logic [GAIN_W-1:0]        gain_dl_reg;
    logic signed [OFFS_W-1:0] offs_dl_reg;
    logic [GAIN_W-1:0]        gain_dh_reg;
    logic signed [OFFS_W-1:0] offs_dh_reg;
    logic [GAIN_W-1:0]        gain_ch_reg;
    logic signed [OFFS_W-1:0] offs_ch_reg;
    logic [CAP_W-1:0]         cap_reg;

    // Sequencer and item registers.
    state_t                   state_reg;
    logic                     mode_reg;
    logic [RAW_W-1:0]         v_reg;
    dir_t                     dir_reg;
    logic signed [OFFS_W-1:0] b_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [CODE_W-1:0]        last_code_reg;

    // Arithmetic unit operands.
    logic                     mul_start_reg;
    logic [NUM_W-1:0]         mul_a_reg;
    logic [MPLIER_W-1:0]      mul_b_reg;
    logic signed [NUM_W-1:0]  mul_init_reg;
    logic                     div_start_reg;
    logic [NUM_W-1:0]         div_a_dvd_reg;
    logic [NUM_W-1:0]         div_b_dvd_reg;
    logic [DVS_W-1:0]         div_a_dvs_reg;
    logic [DVS_W-1:0]         div_b_dvs_reg;

    // Output register.
    logic                     out_valid_reg;
    logic [1:0]               direction_reg;
    logic [CODE_W-1:0]        current_code_reg;
    logic [STEP_W-1:0]        percent_step_reg;
    logic signed [ACC_W-1:0]  charge_sum_reg;

    // Unit results.
    logic signed [NUM_W-1:0]  mul_product;
    unit_status_t             mul_status;
    logic [NUM_W-1:0]         div_a_quo;
    logic [DVS_W-1:0]         div_a_rem;
    unit_status_t             div_a_status;
    logic [NUM_W-1:0]         div_b_quo;
    logic [DVS_W-1:0]         div_b_rem;
    unit_status_t             div_b_status;

    // Combinational helpers.
    logic                     raw_neg;
    logic [RAW_W-1:0]         raw_mag;
    logic                     in_window;
    logic [GAIN_W-1:0]        gain_sel;
    logic signed [OFFS_W-1:0] offs_sel;
    logic [GAIN_W-1:0]        k_eff;
    logic signed [OFFS_W-1:0] b_eff;
    logic signed [NUM_W-1:0]  b_ext;
    logic signed [NUM_W-1:0]  b1000;
    logic                     num_pos;
    logic                     fold_neg;
    logic [ACC_W-1:0]         fold_mag;
    logic [ACC_W-1:0]         fold_mag_adj;
    logic [DVS_W-1:0]         cap_eff;
    logic [ACC_W-1:0]         cur;
    logic [ACC_W-1:0]         rem_ext;
    logic [15:0]              q100;
    logic signed [16:0]       code_wide;
    logic [CODE_W-1:0]        code_next;
    logic signed [ACC_W-1:0]  acc_next;
    logic [STEP_W-1:0]        step_next;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_dl_reg <= K_DEFAULT;
            offs_dl_reg <= '0;
            gain_dh_reg <= K_DEFAULT;
            offs_dh_reg <= '0;
            gain_ch_reg <= K_DEFAULT;
            offs_ch_reg <= '0;
            cap_reg     <= CAP_W'(36000);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAIN_DL: gain_dl_reg <= cfg_data[GAIN_W-1:0];
                CFG_OFFS_DL: offs_dl_reg <= cfg_data[OFFS_W-1:0];
                CFG_GAIN_DH: gain_dh_reg <= cfg_data[GAIN_W-1:0];
                CFG_OFFS_DH: offs_dh_reg <= cfg_data[OFFS_W-1:0];
                CFG_GAIN_CH: gain_ch_reg <= cfg_data[GAIN_W-1:0];
                CFG_OFFS_CH: offs_ch_reg <= cfg_data[OFFS_W-1:0];
                CFG_CAP:     cap_reg     <= cfg_data[CAP_W-1:0];
                default:     ;
            endcase
        end
    end

    // Sample sign: any of the top three bits marks a charge reading.
    always_comb
    begin
        raw_neg = |shunt_raw[RAW_W-1:RAW_W-3];
        raw_mag = raw_neg ? (RAW_W'(0) - shunt_raw) : shunt_raw;
    end

    // Gain and offset pair, with out-of-range values replaced.
    always_comb
    begin
        in_window = (v_reg > WIN_MIN) && (v_reg < WIN_MAX);
        if (dir_reg == DIR_CHARGE)
        begin
            gain_sel = gain_ch_reg;
            offs_sel = offs_ch_reg;
        end
        else if (v_reg < SPLIT)
        begin
            gain_sel = gain_dl_reg;
            offs_sel = offs_dl_reg;
        end
        else
        begin
            gain_sel = gain_dh_reg;
            offs_sel = offs_dh_reg;
        end
        k_eff = ((gain_sel < K_MIN) || (gain_sel > K_MAX)) ? K_DEFAULT : gain_sel;
        b_eff = ((offs_sel > B_LIMIT) || (offs_sel < B_LIMIT_NEG)) ? '0 : offs_sel;
    end

    // Offset times 1000 as 1024 - 16 - 8 shifted copies.
    always_comb
    begin
        b_ext   = NUM_W'(b_reg);
        b1000   = (b_ext <<< 10) - (b_ext <<< 4) - (b_ext <<< 3);
        num_pos = !mul_product[NUM_W-1] && (|mul_product);
    end

    // Fold operands: magnitude of the sum and the nonzero capacity unit.
    always_comb
    begin
        fold_neg     = acc_reg[ACC_W-1];
        fold_mag     = fold_neg ? (ACC_W'(0) - ACC_W'(acc_reg)) : ACC_W'(acc_reg);
        fold_mag_adj = fold_neg ? (fold_mag + SELF_USE) : fold_mag;
        cap_eff      = (cap_reg == '0) ? DVS_W'(1) : DVS_W'(cap_reg);
    end

    // Result of the item once the dividers are done.
    always_comb
    begin
        cur       = div_a_quo[ACC_W-1:0];
        rem_ext   = ACC_W'(div_a_rem);
        q100      = div_b_quo[15:0];
        code_wide = 17'sd0;
        code_next = last_code_reg;
        acc_next  = acc_reg;
        step_next = '0;
        if (!mode_reg)
        begin
            if (dir_reg == DIR_DISCHARGE)
            begin
                code_wide = $signed(17'(CODE_CENTER)) + $signed({1'b0, q100});
                acc_next  = acc_reg - $signed(cur);
            end
            else if (dir_reg == DIR_CHARGE)
            begin
                code_wide = $signed(17'(CODE_CENTER)) - $signed({1'b0, q100});
                acc_next  = acc_reg + $signed(cur);
            end
            else
            begin
                code_wide = $signed(17'(CODE_CENTER));
            end
            if (code_wide < 0)
            begin
                code_next = '0;
            end
            else if (code_wide > $signed(17'(CODE_MAX)))
            begin
                code_next = CODE_MAX;
            end
            else
            begin
                code_next = code_wide[CODE_W-1:0];
            end
        end
        else if (dir_reg != DIR_NONE)
        begin
            acc_next  = (dir_reg == DIR_DISCHARGE) ? $signed(ACC_W'(0) - rem_ext)
                                                   : $signed(rem_ext);
            step_next = div_b_quo[STEP_W-1:0];
        end
    end

    // Sequencer, accumulator and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= 1'b0;
            v_reg            <= '0;
            dir_reg          <= DIR_NONE;
            b_reg            <= '0;
            acc_reg          <= '0;
            last_code_reg    <= CODE_CENTER;
            mul_start_reg    <= 1'b0;
            mul_a_reg        <= '0;
            mul_b_reg        <= '0;
            mul_init_reg     <= '0;
            div_start_reg    <= 1'b0;
            div_a_dvd_reg    <= '0;
            div_b_dvd_reg    <= '0;
            div_a_dvs_reg    <= '0;
            div_b_dvs_reg    <= '0;
            out_valid_reg    <= 1'b0;
            direction_reg    <= '0;
            current_code_reg <= '0;
            percent_step_reg <= '0;
            charge_sum_reg   <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg  <= mode;
                        v_reg     <= raw_mag;
                        dir_reg   <= raw_neg ? DIR_CHARGE : DIR_DISCHARGE;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (!mode_reg)
                    begin
                        if (in_window)
                        begin
                            b_reg         <= b_eff;
                            mul_a_reg     <= NUM_W'(v_reg);
                            mul_b_reg     <= MPLIER_W'(k_eff);
                            mul_init_reg  <= '0;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL1;
                        end
                        else
                        begin
                            dir_reg   <= DIR_NONE;
                            state_reg <= S_FINISH;
                        end
                    end
                    else if (acc_reg == '0)
                    begin
                        dir_reg   <= DIR_NONE;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        dir_reg       <= fold_neg ? DIR_DISCHARGE : DIR_CHARGE;
                        div_a_dvd_reg <= NUM_W'(fold_mag);
                        div_b_dvd_reg <= NUM_W'(fold_mag_adj);
                        div_a_dvs_reg <= cap_eff;
                        div_b_dvs_reg <= cap_eff;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_MUL1:
                begin
                    // Second pass scales v*K by the coefficient on top of B*1000.
                    if (mul_status.done)
                    begin
                        mul_a_reg     <= NUM_W'(mul_product[CAP_W-1:0]);
                        mul_b_reg     <= COEF_UV;
                        mul_init_reg  <= b1000;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL2;
                    end
                end
                S_MUL2:
                begin
                    // A numerator at or below zero calibrates to zero current.
                    if (mul_status.done)
                    begin
                        div_a_dvd_reg <= num_pos ? NUM_W'(mul_product) : '0;
                        div_b_dvd_reg <= num_pos ? NUM_W'(mul_product) : '0;
                        div_a_dvs_reg <= DIV_CUR;
                        div_b_dvs_reg <= DIV_CODE;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_a_status.done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        acc_reg          <= acc_next;
                        last_code_reg    <= code_next;
                        out_valid_reg    <= 1'b1;
                        direction_reg    <= dir_reg;
                        current_code_reg <= code_next;
                        percent_step_reg <= step_next;
                        charge_sum_reg   <= acc_next;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    scc_mul #(
        .A_W (NUM_W),
        .B_W (MPLIER_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .mcand   (mul_a_reg),
        .mplier  (mul_b_reg),
        .init    (mul_init_reg),
        .product (mul_product),
        .status  (mul_status)
    );

    // Divider A yields the current or the fold remainder.
    scc_div #(
        .N_W (NUM_W),
        .D_W (DVS_W)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_a_dvd_reg),
        .divisor   (div_a_dvs_reg),
        .quotient  (div_a_quo),
        .remainder (div_a_rem),
        .status    (div_a_status)
    );

    // Divider B yields the current over 100 or the percent step.
    scc_div #(
        .N_W (NUM_W),
        .D_W (DVS_W)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_b_dvd_reg),
        .divisor   (div_b_dvs_reg),
        .quotient  (div_b_quo),
        .remainder (div_b_rem),
        .status    (div_b_status)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign direction    = direction_reg;
    assign current_code = current_code_reg;
    assign percent_step = percent_step_reg;
    assign charge_sum   = charge_sum_reg;

    // The multiplier only finishes while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_status.done |-> (state_reg == S_MUL1 || state_reg == S_MUL2))
        else $error("multiplier finished outside a multiply phase");

    // Both dividers start together and must finish together in the divide phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_a_status.done || div_b_status.done) |->
            (div_a_status.done && div_b_status.done && state_reg == S_DIV))
        else $error("dividers out of step");

    // A result without direction carries no percent step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && direction == DIR_NONE) |-> (percent_step == '0))
        else $error("percent step without direction");

    // A delivered code stays in range and the direction is a defined code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (current_code <= CODE_MAX && direction <= DIR_CHARGE))
        else $error("result code out of range");

    // The remainder of divider B stays below its divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_b_status.done |-> (div_b_rem < div_b_dvs_reg))
        else $error("divider remainder not below divisor");

endmodule

// File: tb/shunt_current_coulomb_counter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shunt_current_coulomb_counter_top_tb: self-checking bench for the counter
// Drives shunt samples and fold requests through the input channel and
// programs the gain, offset and capacity registers between phases. Every
// result is checked field by field against a cycle-free model of the
// calibration and charge bookkeeping kept inside this bench. A directed table
// covers window edges, the gain split, register limits and folds; random
// phases under varied register settings and flow control follow, and a final
// run of maximum charge samples builds a large charge sum and folds it.
// ----------------------------------------------------------------------------
module shunt_current_coulomb_counter_top_tb;
    import scc_pkg::*;

    // Timing and run length.
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 100;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int PHASE_ITEMS   = 220;
    localparam int RANDOM_PHASES = 8;
    localparam int WRAP_SAMPLES  = 120;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 600;
    localparam int MAX_REPORTS   = 100;

    // Calibration arithmetic.
    localparam logic [15:0] NEG_BITS   = 16'hE000;
    localparam logic [15:0] SPLIT_V    = 16'd375;
    localparam logic [15:0] WIN_LO     = 16'd6;
    localparam logic [15:0] WIN_HI     = 16'd7500;
    localparam longint      MV_PER_LSB = 26667;
    localparam longint      GAIN_LO    = 500;
    localparam longint      GAIN_HI    = 2000;
    localparam longint      GAIN_DFLT  = 1000;
    localparam longint      OFFS_LIM   = 1000000;
    localparam int unsigned SELF_DRAIN = 20;
    localparam int          CENTER     = 5000;
    localparam int          CODE_TOP   = 10000;

    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Register indexes of the three gain/offset pairs, in pair order.
    localparam logic [CFG_IDX_W-1:0] GAIN_IDX [3] = '{CFG_GAIN_DL, CFG_GAIN_DH, CFG_GAIN_CH};
    localparam logic [CFG_IDX_W-1:0] OFFS_IDX [3] = '{CFG_OFFS_DL, CFG_OFFS_DH, CFG_OFFS_CH};

    // Edge values for random register settings and window magnitudes.
    localparam int GAIN_EDGES [6] = '{0, 499, 500, 2000, 2001, 4095};
    localparam int OFFS_EDGES [6] = '{-2000000, -1000001, -1000000, 1000000, 1000001, 2000000};
    localparam int WIN_EDGES  [4] = '{7, 374, 375, 7499};

    typedef struct packed {
        dir_t              dir;
        logic [CODE_W-1:0] code;
        logic [STEP_W-1:0] step;
        logic [ACC_W-1:0]  sum;
    } result_t;

    typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        bit                   fold;
        logic [RAW_W-1:0]     raw;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   reg_val;
        bit                   typed;
        result_t              want;
    } plan_row_t;

    localparam result_t UNTYPED      = '0;
    localparam result_t IDLE_READING = '{DIR_NONE, 14'd5000, 8'd0, 32'd0};

    localparam int PLAN_LEN = 37;

    // Directed table: rows after reset with a typed result, then window and
    // split edges, out-of-range and extreme register values, and folds.
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_ITEM,  1'b1, 16'h0000, CFG_GAIN_DL, 0,        1'b1, IDLE_READING},
        '{ROW_ITEM,  1'b0, 16'h0000, CFG_GAIN_DL, 0,        1'b1, IDLE_READING},
        '{ROW_ITEM,  1'b0, 16'h0006, CFG_GAIN_DL, 0,        1'b1, IDLE_READING},
        '{ROW_ITEM,  1'b0, 16'h1D4C, CFG_GAIN_DL, 0,        1'b1, IDLE_READING},
        '{ROW_ITEM,  1'b0, 16'hFFFF, CFG_GAIN_DL, 0,        1'b1, IDLE_READING},
        '{ROW_ITEM,  1'b0, 16'hE000, CFG_GAIN_DL, 0,        1'b1, IDLE_READING},
        '{ROW_ITEM,  1'b0, 16'h0007, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'h0176, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'h0177, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'h1D4B, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'hFFF9, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'hE2B5, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b1, 16'h5A5A, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_GAIN_DL, 499,      1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_OFFS_DL, -1000000, 1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_GAIN_DH, 2001,     1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_OFFS_DH, 1000001,  1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_GAIN_CH, 2000,     1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_OFFS_CH, -1000001, 1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_CAP,     0,        1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_UNUSED,  16777215, 1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'h0007, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'h0177, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'hFFF9, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b1, 16'hFFFF, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_GAIN_DL, 500,      1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_OFFS_DL, 1000000,  1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_GAIN_DH, 0,        1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_OFFS_DH, -2000000, 1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_GAIN_CH, 4095,     1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_OFFS_CH, 2000000,  1'b0, UNTYPED},
        '{ROW_WRITE, 1'b0, 16'h0000, CFG_CAP,     16777215, 1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'h0100, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'h1000, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b0, 16'hF000, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b1, 16'h0000, CFG_GAIN_DL, 0,        1'b0, UNTYPED},
        '{ROW_ITEM,  1'b1, 16'h0000, CFG_GAIN_DL, 0,        1'b0, UNTYPED}
    };

    // Block ports.
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     mode      = 1'b0;
    logic [RAW_W-1:0]         shunt_raw = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               direction;
    logic [CODE_W-1:0]        current_code;
    logic [STEP_W-1:0]        percent_step;
    logic signed [ACC_W-1:0]  charge_sum;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DAT_W-1:0]     cfg_data  = '0;

    // Model state: registers, charge sum and the last reported current code.
    logic [GAIN_W-1:0]        gain_reg [3] = '{12'd1000, 12'd1000, 12'd1000};
    logic signed [OFFS_W-1:0] offs_reg [3] = '{22'sd0, 22'sd0, 22'sd0};
    logic [CAP_W-1:0]         cap_reg      = 24'd36000;
    logic [ACC_W-1:0]         charge_acc   = '0;
    logic [CODE_W-1:0]        last_code    = 14'd5000;

    result_t expected_readings [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      stall_pct      = 0;
    int      hold_left      = 0;
    bit      hold_done      = 1'b0;

    shunt_current_coulomb_counter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .shunt_raw    (shunt_raw),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .direction    (direction),
        .current_code (current_code),
        .percent_step (percent_step),
        .charge_sum   (charge_sum),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Calibrated current in units of the sample word, with the gain and
    // offset limits applied and negative currents clipped to zero.
    function automatic int unsigned calibrated_current(int unsigned v, int pair);
        longint k;
        longint b;
        longint num;
        k = gain_reg[pair];
        b = offs_reg[pair];
        if (k < GAIN_LO || k > GAIN_HI)
            k = GAIN_DFLT;
        if (b > OFFS_LIM || b < -OFFS_LIM)
            b = 0;
        num = longint'(v) * MV_PER_LSB * k + b * 1000;
        if (num <= 0)
            return 0;
        return 32'(num / 1000000);
    endfunction

    // Advances the charge bookkeeping by one transfer and returns the result.
    function automatic result_t count_charge(bit fold, logic [RAW_W-1:0] raw);
        result_t          r;
        logic [RAW_W-1:0] mag16;
        int unsigned      cur;
        int unsigned      cap;
        int unsigned      mag;
        int unsigned      rem;
        int               code;
        r.dir  = DIR_NONE;
        r.step = '0;
        if (!fold) begin
            // A word with any of the top three bits set is a charge sample.
            mag16 = raw;
            r.dir = DIR_DISCHARGE;
            cur   = 0;
            if ((raw & NEG_BITS) != '0) begin
                mag16 = 16'd0 - raw;
                r.dir = DIR_CHARGE;
            end
            if (mag16 > WIN_LO && mag16 < WIN_HI) begin
                if (r.dir == DIR_DISCHARGE) begin
                    cur = calibrated_current(mag16, (mag16 < SPLIT_V) ? 0 : 1);
                    charge_acc = charge_acc - cur;
                end
                else begin
                    cur = calibrated_current(mag16, 2);
                    charge_acc = charge_acc + cur;
                end
            end
            else begin
                r.dir = DIR_NONE;
            end
            if (r.dir == DIR_DISCHARGE)
                code = CENTER + int'(cur / 100);
            else
                code = CENTER - int'(cur / 100);
            if (code < 0)
                code = 0;
            if (code > CODE_TOP)
                code = CODE_TOP;
            last_code = code[CODE_W-1:0];
        end
        else if (charge_acc != '0) begin
            // Fold whole capacity steps out of the sum and keep the remainder.
            cap = (cap_reg == '0) ? 1 : cap_reg;
            mag = charge_acc[ACC_W-1] ? 32'd0 - charge_acc : charge_acc;
            rem = mag % cap;
            if (charge_acc[ACC_W-1]) begin
                r.dir      = DIR_DISCHARGE;
                r.step     = 8'((mag + SELF_DRAIN) / cap);
                charge_acc = 32'd0 - rem;
            end
            else begin
                r.dir      = DIR_CHARGE;
                r.step     = 8'(mag / cap);
                charge_acc = rem;
            end
        end
        r.code = last_code;
        r.sum  = charge_acc;
        return r;
    endfunction

    // Offers one item, waits for its transfer and queues its expected result.
    // Valid stays high afterwards so that the next item follows without a gap.
    task automatic drive_item(bit fold, logic [RAW_W-1:0] raw, bit typed, result_t typed_want);
        logic    busy;
        result_t predicted;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        mode      <= fold;
        shunt_raw <= raw;
        do begin
            @(negedge clk);
            busy = in_stall;
            @(posedge clk);
        end while (busy);
        predicted = count_charge(fold, raw);
        expected_readings.push_back(typed ? typed_want : predicted);
    endtask

    // Drops valid and waits until every queued result has come out.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register through the configuration channel.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        logic ready_seen;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DAT_W-1:0];
        do begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end while (!ready_seen);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN_DL: gain_reg[0] = value[GAIN_W-1:0];
            CFG_OFFS_DL: offs_reg[0] = value[OFFS_W-1:0];
            CFG_GAIN_DH: gain_reg[1] = value[GAIN_W-1:0];
            CFG_OFFS_DH: offs_reg[1] = value[OFFS_W-1:0];
            CFG_GAIN_CH: gain_reg[2] = value[GAIN_W-1:0];
            CFG_OFFS_CH: offs_reg[2] = value[OFFS_W-1:0];
            CFG_CAP:     cap_reg     = value[CAP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic flag_mismatch(string field, longint want_v, longint got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // Receiver stall: random per phase, plus one long hold-off that lets the
    // block fill up while the sender keeps offering items.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result check, sampled mid-cycle ahead of the transfer edge.
    always @(negedge clk) begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, got sum %0d",
                             $time, charge_sum);
            end
            else begin
                want = expected_readings.pop_front();
                if (direction !== want.dir)
                    flag_mismatch("direction", want.dir, direction);
                if (current_code !== want.code)
                    flag_mismatch("current_code", want.code, current_code);
                if (percent_step !== want.step)
                    flag_mismatch("percent_step", want.step, percent_step);
                if (charge_sum !== want.sum)
                    flag_mismatch("charge_sum", $signed(want.sum), charge_sum);
            end
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        plan_row_t        row;
        int unsigned      v;
        int               sel;
        int               value;
        logic [RAW_W-1:0] raw;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_WRITE) begin
                wait_until_idle();
                write_register(row.reg_idx, row.reg_val);
            end
            else begin
                drive_item(row.fold, row.raw, row.typed, row.want);
            end
        end

        // Random phases, each with fresh register settings and flow control.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_until_idle();
            for (int k = 0; k < 3; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    value = $urandom_range(500, 2000);
                else if (sel == 6)
                    value = $urandom_range(0, 4095);
                else
                    value = GAIN_EDGES[$urandom_range(0, 5)];
                write_register(GAIN_IDX[k], value);
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    value = int'($urandom_range(0, 2000000)) - 1000000;
                else if (sel < 8)
                    value = int'($urandom_range(0, 4000000)) - 2000000;
                else
                    value = OFFS_EDGES[$urandom_range(0, 5)];
                write_register(OFFS_IDX[k], value);
            end
            case ($urandom_range(0, 5))
                0:       value = 1;
                1:       value = $urandom_range(2, 255);
                2:       value = $urandom_range(256, 65535);
                3:       value = 36000;
                4:       value = 16777215;
                default: value = $urandom_range(1, 16777215);
            endcase
            write_register(CFG_CAP, value);

            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase

            // Mostly in-window samples of both signs, some folds and raw noise.
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 15) begin
                    drive_item(1'b1, 16'($urandom), 1'b0, UNTYPED);
                end
                else begin
                    if ($urandom_range(0, 9) == 0)
                        v = WIN_EDGES[$urandom_range(0, 3)];
                    else
                        v = $urandom_range(7, 7499);
                    if (sel < 55)
                        raw = 16'(v);
                    else if (sel < 88)
                        raw = 16'd0 - 16'(v);
                    else
                        raw = 16'($urandom);
                    drive_item(1'b0, raw, 1'b0, UNTYPED);
                end
            end
        end

        // Clear the sum, then build it up with maximum charge samples and
        // fold the large value.
        wait_until_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_register(CFG_GAIN_CH, 2000);
        write_register(CFG_OFFS_CH, 1000000);
        write_register(CFG_CAP, 1);
        drive_item(1'b1, 16'h0000, 1'b0, UNTYPED);
        for (int n = 0; n < WRAP_SAMPLES; n++)
            drive_item(1'b0, 16'hE2B5, 1'b0, UNTYPED);
        drive_item(1'b1, 16'h0000, 1'b0, UNTYPED);

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
